// File: rtl/bt_pkg.sv
// ----------------------------------------------------------------------------
// bt_pkg
// shared types, character codes, token kinds and helpers for the bencode
// tokenizer
// ----------------------------------------------------------------------------
package bt_pkg;

    // default width of the running byte offset
    localparam int OFFSET_WIDTH_DEF = 32;

    // configuration port
    localparam int          APB_ADDR_WIDTH = 3;
    localparam int          APB_DATA_WIDTH = 32;
    localparam logic [0:0]  REG_MSG_LEN    = 1'd0;
    localparam logic [31:0] MSG_LEN_RESET  = 32'd1;

    // characters
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_I     = 8'h69;
    localparam logic [7:0] CH_L     = 8'h6C;
    localparam logic [7:0] CH_D     = 8'h64;
    localparam logic [7:0] CH_E     = 8'h65;

    // token kinds
    localparam logic [3:0] K_I      = 4'd0;
    localparam logic [3:0] K_L      = 4'd1;
    localparam logic [3:0] K_D      = 4'd2;
    localparam logic [3:0] K_E      = 4'd3;
    localparam logic [3:0] K_COLON  = 4'd4;
    localparam logic [3:0] K_INT    = 4'd5;
    localparam logic [3:0] K_HEADER = 4'd6;
    localparam logic [3:0] K_SBYTE  = 4'd7;
    localparam logic [3:0] K_ERROR  = 4'd8;

    // error kinds
    localparam logic ERR_UNEXPECTED = 1'b0;
    localparam logic ERR_BAD_INT    = 1'b1;

    // overflow limit: acc*10+d leaves range when acc > q or acc == q and d > r
    localparam logic [63:0] OVF_QUOT    = 64'd922337203685477580;
    localparam logic [3:0]  OVF_POS_REM = 4'd7;
    localparam logic [3:0]  OVF_NEG_REM = 4'd8;

    // results one byte can cause
    localparam int RES_SLOTS = 3;

    typedef struct packed {
        logic [3:0]  token_kind;
        logic [63:0] number_value;
        logic [7:0]  data_byte;
        logic        error_kind;
        logic [31:0] error_position;
        logic        overflowed;
        logic        run_last;
        logic        message_end;
    } res_t;

    typedef res_t [RES_SLOTS-1:0] res_vec_t;

    // scanner to queue
    typedef struct packed {
        logic       load;
        logic [1:0] count;
    } rq_t;

    // queue status
    typedef struct packed {
        logic       take;
        logic [1:0] count;
    } qs_t;

    function automatic res_t make_res(
        input logic [3:0]  kind,
        input logic [63:0] value,
        input logic [7:0]  data,
        input logic        ek,
        input logic [31:0] pos,
        input logic        ovf
    );
        res_t r;
        r.token_kind     = kind;
        r.number_value   = value;
        r.data_byte      = data;
        r.error_kind     = ek;
        r.error_position = pos;
        r.overflowed     = ovf;
        r.run_last       = 1'b0;
        r.message_end    = 1'b0;
        return r;
    endfunction

endpackage

// File: rtl/bt_intf.sv
// ----------------------------------------------------------------------------
// bt_intf
// byte input channel and token output channel of the bencode tokenizer
// ----------------------------------------------------------------------------
interface bt_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface bt_token_if;
    logic               valid;
    logic               ready;
    logic [3:0]         token_kind;
    logic signed [63:0] number_value;
    logic [7:0]         data_byte;
    logic               error_kind;
    logic [31:0]        error_position;
    logic               overflowed;
    logic               run_last;
    logic               message_end;

    modport source (
        output valid, output token_kind, output number_value, output data_byte,
        output error_kind, output error_position, output overflowed,
        output run_last, output message_end,
        input  ready
    );
    modport sink (
        input  valid, input token_kind, input number_value, input data_byte,
        input  error_kind, input error_position, input overflowed,
        input  run_last, input message_end,
        output ready
    );
endinterface

// File: rtl/bt_cfg.sv
// ----------------------------------------------------------------------------
// bt_cfg
// apb register file holding the message length
// ----------------------------------------------------------------------------
module bt_cfg
    import bt_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [APB_ADDR_WIDTH-1:0] paddr,
    input  logic [APB_DATA_WIDTH-1:0] pwdata,
    output logic [APB_DATA_WIDTH-1:0] prdata,
    output logic                      pready,
    output logic [31:0]               msg_len
);

    logic [31:0] msg_len_reg;
    logic        sel_len;
    logic        wr_en;

    assign pready  = 1'b1;
    assign sel_len = (paddr[APB_ADDR_WIDTH-1:2] == REG_MSG_LEN);
    assign wr_en   = psel && penable && pwrite && pready && sel_len;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            msg_len_reg <= MSG_LEN_RESET;
        end
        else if (wr_en)
        begin
            msg_len_reg <= pwdata;
        end
    end

    assign prdata  = sel_len ? msg_len_reg : '0;
    assign msg_len = msg_len_reg;

endmodule

// File: rtl/bt_scan.sv
// ----------------------------------------------------------------------------
// bt_scan
// input byte register and the scanner: decodes one byte against the scan
// state and builds up to three results in one pass
// ----------------------------------------------------------------------------
module bt_scan
    import bt_pkg::*;
#(
    parameter int OFFSET_WIDTH = OFFSET_WIDTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    bt_byte_if.sink     bytes,
    input  logic [31:0] msg_len,
    input  qs_t         qs,
    output rq_t         rq,
    output res_vec_t    slots
);

    typedef enum logic [4:0] {
        M_IDLE   = 5'b00001,
        M_NEG    = 5'b00010,
        M_INT    = 5'b00100,
        M_STRING = 5'b01000,
        M_ERROR  = 5'b10000
    } mode_t;

    logic [7:0]              byte_reg;
    logic                    full_reg;
    logic                    load;

    mode_t                   mode_reg, mode_next;
    logic [63:0]             acc_reg, acc_next;
    logic                    neg_reg, neg_next;
    logic [OFFSET_WIDTH-1:0] tso_reg, tso_next;
    logic [OFFSET_WIDTH-1:0] off_reg, off_next;
    logic [31:0]             left_reg, left_next;
    logic                    pwn_reg, pwn_next;
    logic                    ovf_reg, ovf_next;

    logic [63:0] p_ext, tso_ext, msg_len_ext, rem, acc_mul, int_val;
    logic [3:0]  dig;
    logic        is_digit, is_nz_digit, ovf_step, last, was_num, do_idle;
    logic [1:0]  n;

    // input register
    assign load        = full_reg && qs.take;
    assign bytes.ready = !full_reg || load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else if (bytes.valid && bytes.ready)
        begin
            full_reg <= 1'b1;
        end
        else if (load)
        begin
            full_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (bytes.valid && bytes.ready)
        begin
            byte_reg <= bytes.in_byte;
        end
    end

    // byte-independent terms
    assign p_ext       = {{(64-OFFSET_WIDTH){1'b0}}, off_reg};
    assign tso_ext     = {{(64-OFFSET_WIDTH){1'b0}}, tso_reg};
    assign msg_len_ext = {32'd0, msg_len};
    assign last        = (p_ext + 64'd1) >= msg_len_ext;
    assign rem         = (msg_len_ext > p_ext) ? (msg_len_ext - p_ext) : 64'd0;
    assign int_val     = neg_reg ? (64'd0 - acc_reg) : acc_reg;

    assign dig         = byte_reg[3:0];
    assign is_digit    = (byte_reg >= CH_ZERO) && (byte_reg <= CH_NINE);
    assign is_nz_digit = (byte_reg >= CH_ONE) && (byte_reg <= CH_NINE);
    assign acc_mul     = (acc_reg << 3) + (acc_reg << 1) + {60'd0, dig};
    assign ovf_step    = (acc_reg > OVF_QUOT) ||
                         ((acc_reg == OVF_QUOT) &&
                          (dig > (neg_reg ? OVF_NEG_REM : OVF_POS_REM)));

    always_comb
    begin
        mode_next = mode_reg;
        acc_next  = acc_reg;
        neg_next  = neg_reg;
        tso_next  = tso_reg;
        off_next  = off_reg;
        left_next = left_reg;
        pwn_next  = pwn_reg;
        ovf_next  = ovf_reg;
        slots     = '0;
        n         = 2'd0;
        was_num   = pwn_reg;
        do_idle   = 1'b0;

        unique case (mode_reg)
            M_STRING:
            begin
                slots[0] = make_res(K_SBYTE, 64'd0, byte_reg, 1'b0, 32'd0, 1'b0);
                n = 2'd1;
                if (left_reg <= 32'd1)
                begin
                    left_next = 32'd0;
                    mode_next = M_IDLE;
                end
                else
                begin
                    left_next = left_reg - 32'd1;
                end
            end
            M_ERROR:
            begin
                mode_next = M_ERROR;
            end
            M_NEG:
            begin
                if (is_nz_digit)
                begin
                    mode_next = M_INT;
                    acc_next  = {60'd0, dig};
                end
                else
                begin
                    slots[0] = make_res(K_ERROR, 64'd0, 8'd0, ERR_BAD_INT,
                                        tso_ext[31:0], 1'b0);
                    n = 2'd1;
                    mode_next = M_ERROR;
                end
            end
            M_INT:
            begin
                if (is_digit)
                begin
                    if (ovf_step)
                    begin
                        ovf_next = 1'b1;
                    end
                    acc_next = acc_mul;
                end
                else
                begin
                    // the terminating byte is scanned again as a new token
                    slots[0] = make_res(K_INT, int_val, 8'd0, 1'b0, 32'd0, ovf_reg);
                    n = 2'd1;
                    was_num   = !ovf_reg;
                    mode_next = M_IDLE;
                    do_idle   = 1'b1;
                end
            end
            default:
            begin
                mode_next = M_IDLE;
                do_idle   = 1'b1;
            end
        endcase

        if (do_idle)
        begin
            pwn_next = 1'b0;
            unique case (byte_reg)
                CH_I:
                begin
                    slots[n] = make_res(K_I, 64'd0, 8'd0, 1'b0, 32'd0, 1'b0);
                    n = n + 2'd1;
                end
                CH_L:
                begin
                    slots[n] = make_res(K_L, 64'd0, 8'd0, 1'b0, 32'd0, 1'b0);
                    n = n + 2'd1;
                end
                CH_D:
                begin
                    slots[n] = make_res(K_D, 64'd0, 8'd0, 1'b0, 32'd0, 1'b0);
                    n = n + 2'd1;
                end
                CH_E:
                begin
                    slots[n] = make_res(K_E, 64'd0, 8'd0, 1'b0, 32'd0, 1'b0);
                    n = n + 2'd1;
                end
                CH_COLON:
                begin
                    slots[n] = make_res(K_COLON, 64'd0, 8'd0, 1'b0, 32'd0, 1'b0);
                    n = n + 2'd1;
                    // string header only when the length fits in the rest
                    if (was_num && !neg_reg && (acc_reg < rem))
                    begin
                        slots[n] = make_res(K_HEADER, acc_reg, 8'd0, 1'b0, 32'd0, 1'b0);
                        n = n + 2'd1;
                        if (acc_reg != 64'd0)
                        begin
                            left_next = acc_reg[31:0];
                            mode_next = M_STRING;
                        end
                    end
                end
                CH_MINUS:
                begin
                    mode_next = M_NEG;
                    tso_next  = off_reg;
                    neg_next  = 1'b1;
                    acc_next  = 64'd0;
                    ovf_next  = 1'b0;
                end
                CH_ZERO:
                begin
                    neg_next = 1'b0;
                    acc_next = 64'd0;
                    ovf_next = 1'b0;
                    slots[n] = make_res(K_INT, 64'd0, 8'd0, 1'b0, 32'd0, 1'b0);
                    n = n + 2'd1;
                    pwn_next = 1'b1;
                end
                default:
                begin
                    if (is_nz_digit)
                    begin
                        mode_next = M_INT;
                        tso_next  = off_reg;
                        neg_next  = 1'b0;
                        acc_next  = {60'd0, dig};
                        ovf_next  = 1'b0;
                    end
                    else
                    begin
                        slots[n] = make_res(K_ERROR, 64'd0, 8'd0, ERR_UNEXPECTED,
                                            p_ext[31:0], 1'b0);
                        n = n + 2'd1;
                        mode_next = M_ERROR;
                    end
                end
            endcase
        end

        if (last)
        begin
            // close an open integer at message end
            if (mode_next == M_NEG)
            begin
                // a pending minus can only be the byte just scanned
                slots[n] = make_res(K_ERROR, 64'd0, 8'd0, ERR_BAD_INT,
                                    p_ext[31:0], 1'b0);
                n = n + 2'd1;
            end
            else if (mode_next == M_INT)
            begin
                slots[n] = make_res(K_INT, neg_next ? (64'd0 - acc_next) : acc_next,
                                    8'd0, 1'b0, 32'd0, ovf_next);
                n = n + 2'd1;
            end
            mode_next = M_IDLE;
            acc_next  = 64'd0;
            neg_next  = 1'b0;
            tso_next  = '0;
            off_next  = '0;
            left_next = 32'd0;
            pwn_next  = 1'b0;
            ovf_next  = 1'b0;
        end
        else
        begin
            off_next = off_reg + {{(OFFSET_WIDTH-1){1'b0}}, 1'b1};
        end

        if (n != 2'd0)
        begin
            slots[n - 2'd1].run_last    = 1'b1;
            slots[n - 2'd1].message_end = last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_IDLE;
            acc_reg  <= 64'd0;
            neg_reg  <= 1'b0;
            tso_reg  <= '0;
            off_reg  <= '0;
            left_reg <= 32'd0;
            pwn_reg  <= 1'b0;
            ovf_reg  <= 1'b0;
        end
        else if (load)
        begin
            mode_reg <= mode_next;
            acc_reg  <= acc_next;
            neg_reg  <= neg_next;
            tso_reg  <= tso_next;
            off_reg  <= off_next;
            left_reg <= left_next;
            pwn_reg  <= pwn_next;
            ovf_reg  <= ovf_next;
        end
    end

    assign rq.load  = load;
    assign rq.count = n;

endmodule

// File: rtl/bt_outq.sv
// ----------------------------------------------------------------------------
// bt_outq
// three-entry result register that takes all results of one byte at once
// and hands them out one per cycle while tokens.ready is high
// ----------------------------------------------------------------------------
module bt_outq
    import bt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  rq_t         rq,
    input  res_vec_t    slots,
    output qs_t         qs,
    bt_token_if.source  tokens
);

    res_vec_t   ent_reg;
    logic [1:0] cnt_reg;
    logic       pop;

    assign pop     = tokens.valid && tokens.ready;
    // refill when empty or when the last entry leaves this cycle
    assign qs.take  = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && pop);
    assign qs.count = cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else if (rq.load)
        begin
            cnt_reg <= rq.count;
        end
        else if (pop)
        begin
            cnt_reg <= cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rq.load)
        begin
            ent_reg <= slots;
        end
        else if (pop)
        begin
            ent_reg[0] <= ent_reg[1];
            ent_reg[1] <= ent_reg[2];
        end
    end

    assign tokens.valid          = (cnt_reg != 2'd0);
    assign tokens.token_kind     = ent_reg[0].token_kind;
    assign tokens.number_value   = $signed(ent_reg[0].number_value);
    assign tokens.data_byte      = ent_reg[0].data_byte;
    assign tokens.error_kind     = ent_reg[0].error_kind;
    assign tokens.error_position = ent_reg[0].error_position;
    assign tokens.overflowed     = ent_reg[0].overflowed;
    assign tokens.run_last       = ent_reg[0].run_last;
    assign tokens.message_end    = ent_reg[0].message_end;

endmodule

// File: rtl/bencode_tokenizer.sv
// ----------------------------------------------------------------------------
// bencode_tokenizer
// streaming bencode tokenizer: one message byte in, markers, integers,
// string headers, string bytes and errors out
// ----------------------------------------------------------------------------
// Bytes enter on the bytes channel and tokens leave on the tokens channel; the
// message length lives in the register at byte address 0 and should be
// written while the block is idle. An accepted byte waits in the input
// register until the result register can take its results, is decoded in a
// single pass against the scan state and its results (zero to three) land
// together in a three-entry result register, from which the first token of
// the byte is offered.
// The result register drains one token per cycle while tokens.ready is high
// and takes the next byte's results as its last entry leaves, so the
// sustained rate is one byte per cycle when no byte yields more than one
// token and the consumer is ready. Every byte's last token carries run_last,
// and on the message's last byte also message_end.
module bencode_tokenizer
    import bt_pkg::*;
#(
    parameter int OFFSET_WIDTH = OFFSET_WIDTH_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [APB_ADDR_WIDTH-1:0] paddr,
    input  logic [APB_DATA_WIDTH-1:0] pwdata,
    output logic [APB_DATA_WIDTH-1:0] prdata,
    output logic                      pready,
    bt_byte_if.sink                   bytes,
    bt_token_if.source                tokens
);

    logic [31:0] msg_len;
    rq_t         rq;
    qs_t         qs;
    res_vec_t    slots;

    bt_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .msg_len (msg_len)
    );

    bt_scan #(
        .OFFSET_WIDTH (OFFSET_WIDTH)
    ) u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .bytes   (bytes),
        .msg_len (msg_len),
        .qs      (qs),
        .rq      (rq),
        .slots   (slots)
    );

    bt_outq u_outq (
        .clk    (clk),
        .rst_n  (rst_n),
        .rq     (rq),
        .slots  (slots),
        .qs     (qs),
        .tokens (tokens)
    );

    // a byte that yields results offers a token in the next cycle
    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        rq.load && (rq.count != 2'd0) |=> tokens.valid)
        else $error("results of a decoded byte not offered");

    // queue only refilled when it is free or its last entry leaves
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        rq.load |-> (qs.count == 2'd0) ||
                    ((qs.count == 2'd1) && tokens.valid && tokens.ready))
        else $error("result queue overwritten");

    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        tokens.valid && tokens.message_end |-> tokens.run_last)
        else $error("message end on a token that is not the last of its byte");

    a_ovf_on_int: assert property (@(posedge clk) disable iff (!rst_n)
        tokens.valid && tokens.overflowed |-> (tokens.token_kind == K_INT))
        else $error("overflow flag on a token that is not an integer");

endmodule
